FILE: src/universal_hash_table_macros.svh
// Assertion helpers used by the hash table control module.
`ifndef UNIVERSAL_HASH_TABLE_MACROS_SVH
`define UNIVERSAL_HASH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define UHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define UHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/uht_pkg.sv
package uht_pkg;

    localparam int DEF_MAX_BUCKETS  = 1024;
    localparam int DEF_BUCKET_SLOTS = 8;

    localparam logic [29:0] HASH_PRIME  = 30'd1000000007;
    localparam logic [32:0] RECIP_PRIME = 33'd4611685986;
    localparam int          SPILL_LIMIT = 5;
    localparam int          DVD_W       = 30;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] REG_HASH_A     = 2'd0;
    localparam logic [1:0] REG_HASH_B     = 2'd1;
    localparam logic [1:0] REG_TABLE_SIZE = 2'd2;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLR,
        CMD_LOAD,
        CMD_MUL,
        CMD_ADD,
        CMD_RECIP,
        CMD_QMUL,
        CMD_SUBQ,
        CMD_CORR,
        CMD_FIXP,
        CMD_HOME,
        CMD_RDCNT,
        CMD_NEXT,
        CMD_FULL,
        CMD_INS,
        CMD_SCAN,
        CMD_RDKEY,
        CMD_HIT,
        CMD_ADV,
        CMD_DEL,
        CMD_BEND,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic red_ge_p;
        logic clr_last;
        logic is_ins;
        logic is_del;
        logic home_phase;
        logic spill_differs;
        logic cnt_over;
        logic cnt_full;
        logic scan_end;
        logic key_eq;
    } t_status;

endpackage

FILE: src/universal_hash_table.sv
// Bucketed hash table of signed 32-bit keys with a universal hash.
// Request channel: drive action and key with start; a request is taken on
// a clock edge where start is high and busy is low. Result channel: o_valid
// pulses for one cycle with o_bucket_index and o_status; there is no
// backpressure, so the user must capture it in that cycle.
// Configuration: i_cfg_index/i_cfg_data are written when i_cfg_valid and
// o_cfg_ready are high (0 hash_a, 1 hash_b, 2 table_size); write only
// while busy is low and no result is pending.
// Sequence: multiply, add, reciprocal estimate, quotient multiply and
// subtract, then corrections finish the remainder by the prime, and a
// 30-step serial remainder by the table size gives the home bucket. Each
// bucket visit then reads the count and dispatches; a search or delete reads
// and compares each stored key scanned and ends each bucket, and a final
// state issues the result. busy drops in the strobe cycle, so a new
// transaction is taken only once the previous result has been issued.
// After reset busy stays high while the bucket counts are swept to zero;
// configuration writes are taken then too.
module universal_hash_table
    import uht_pkg::*;
#(
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_key,
    output logic               o_valid,
    output logic [9:0]         o_bucket_index,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    uht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    uht_dp #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_bucket_index (o_bucket_index),
        .o_status       (o_status)
    );

    assign o_cfg_ready = 1'b1;

endmodule

FILE: src/uht_divmod.sv
module uht_divmod
    import uht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [29:0]       i_divisor,
    output logic              o_done,
    output logic [29:0]       o_rem
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [29:0]      r_div;
    logic [29:0]      r_rem;
    logic [30:0]      trial;
    logic [30:0]      n_rem;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign n_rem = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem[29:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: src/uht_dp.sv
module uht_dp
    import uht_pkg::*;
#(
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_st,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_key,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic [9:0]         o_bucket_index,
    output logic [1:0]         o_status
);

    localparam int BW    = $clog2(MAX_BUCKETS);
    localparam int SW    = $clog2(MAX_BUCKETS + 1);
    localparam int CW    = $clog2(BUCKET_SLOTS + 1);
    localparam int KDEPTH = MAX_BUCKETS * BUCKET_SLOTS;
    localparam int KAW   = $clog2(KDEPTH);

    logic [31:0]        key_mem [KDEPTH];
    logic [CW-1:0]      cnt_mem [MAX_BUCKETS];

    logic [29:0]        r_a;
    logic [29:0]        r_b;
    logic [10:0]        r_size;
    logic [1:0]         r_act;
    logic signed [31:0] r_key;
    logic signed [62:0] r_prod;
    logic               r_neg;
    logic [61:0]        r_abs;
    logic [32:0]        r_quo;
    logic [61:0]        r_qp;
    logic [31:0]        r_red;
    logic [BW-1:0]      r_home;
    logic [BW-1:0]      r_spill;
    logic [BW-1:0]      r_cur;
    logic               r_phase;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_w;
    logic [BW-1:0]      r_idx;
    logic [1:0]         r_stat;
    logic [BW-1:0]      r_clr;
    logic               r_valid;
    logic [CW-1:0]      r_cnt_q;
    logic [31:0]        r_key_q;

    logic [SW-1:0]      eff_size;
    logic signed [30:0] a_s;
    logic signed [62:0] prod_w;
    logic signed [62:0] v_w;
    logic signed [62:0] abs_w;
    logic [65:0]        recip_w;
    logic [62:0]        qp_w;
    logic [61:0]        diff_w;
    logic [29:0]        fix_w;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [29:0]        div_dsr;
    logic               div_done;
    logic [29:0]        div_rem;
    logic [BW-1:0]      home_w;
    logic [SW-1:0]      home_p1;
    logic [BW-1:0]      spill_w;
    logic [KAW-1:0]     base_w;
    logic [BW+9:0]      idx_ext;

    always_comb begin
        if (r_size == 11'd0) begin
            eff_size = SW'(1);
        end else if (32'(r_size) > 32'(MAX_BUCKETS)) begin
            eff_size = SW'(MAX_BUCKETS);
        end else begin
            eff_size = SW'(r_size);
        end
    end

    assign a_s     = $signed({1'b0, r_a});
    assign prod_w  = a_s * r_key;
    assign v_w     = r_prod + $signed({33'b0, r_b});
    assign abs_w   = v_w[62] ? -v_w : v_w;
    assign recip_w = r_abs[61:29] * RECIP_PRIME;
    assign qp_w    = r_quo * HASH_PRIME;
    assign diff_w  = r_abs - r_qp;
    assign fix_w   = (r_neg && r_red[29:0] != 30'd0) ? HASH_PRIME - r_red[29:0] : r_red[29:0];

    assign div_start = (i_cmd == CMD_FIXP);
    assign div_dvd   = fix_w;
    assign div_dsr   = 30'(eff_size);

    uht_divmod u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign home_w  = div_rem[BW-1:0];
    assign home_p1 = SW'(home_w) + SW'(1);
    assign spill_w = (home_p1 == eff_size) ? '0 : home_p1[BW-1:0];
    assign base_w  = KAW'(r_cur) * KAW'(BUCKET_SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= 30'd1;
            r_b    <= 30'd0;
            r_size <= 11'd1024;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HASH_A:     r_a    <= i_cfg_data[29:0];
                REG_HASH_B:     r_b    <= i_cfg_data[29:0];
                REG_TABLE_SIZE: r_size <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd == CMD_OUT);
            if (i_cmd == CMD_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_act <= i_action;
                r_key <= i_key;
            end
            CMD_MUL: r_prod <= prod_w;
            CMD_ADD: begin
                r_neg <= v_w[62];
                r_abs <= abs_w[61:0];
            end
            CMD_RECIP: r_quo <= recip_w[65:33];
            CMD_QMUL:  r_qp  <= qp_w[61:0];
            CMD_SUBQ:  r_red <= diff_w[31:0];
            CMD_CORR:  r_red <= r_red - {2'b0, HASH_PRIME};
            CMD_HOME: begin
                r_home  <= home_w;
                r_spill <= spill_w;
                r_cur   <= home_w;
                r_phase <= 1'b0;
                r_idx   <= home_w;
                r_stat  <= ST_MISS;
            end
            CMD_NEXT: begin
                r_cur   <= r_spill;
                r_phase <= 1'b1;
            end
            CMD_FULL: begin
                r_idx  <= r_cur;
                r_stat <= ST_FULL;
            end
            CMD_INS: begin
                r_idx  <= r_cur;
                r_stat <= ST_DONE;
            end
            CMD_SCAN: begin
                r_i <= '0;
                r_w <= '0;
            end
            CMD_HIT: begin
                r_idx  <= r_cur;
                r_stat <= ST_DONE;
            end
            CMD_ADV: r_i <= r_i + 1'b1;
            CMD_DEL: begin
                r_i <= r_i + 1'b1;
                if (r_key_q != r_key) begin
                    r_w <= r_w + 1'b1;
                end
            end
            CMD_BEND: begin
                if (r_act == ACT_DELETE && r_w != r_cnt_q && r_stat != ST_DONE) begin
                    r_idx  <= r_cur;
                    r_stat <= ST_DONE;
                end
                if (!r_phase && r_spill != r_home) begin
                    r_cur   <= r_spill;
                    r_phase <= 1'b1;
                    r_i     <= '0;
                    r_w     <= '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_CLR:  cnt_mem[r_clr] <= '0;
            CMD_INS:  cnt_mem[r_cur] <= r_cnt_q + 1'b1;
            CMD_BEND: begin
                if (r_act == ACT_DELETE) begin
                    cnt_mem[r_cur] <= r_w;
                end
            end
            default: ;
        endcase
        if (i_cmd == CMD_RDCNT) begin
            r_cnt_q <= cnt_mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_INS: key_mem[base_w + KAW'(r_cnt_q)] <= r_key;
            CMD_DEL: begin
                if (r_key_q != r_key) begin
                    key_mem[base_w + KAW'(r_w)] <= r_key_q;
                end
            end
            default: ;
        endcase
        if (i_cmd == CMD_RDKEY) begin
            r_key_q <= key_mem[base_w + KAW'(r_i)];
        end
    end

    assign o_st.div_done      = div_done;
    assign o_st.red_ge_p      = (r_red >= {2'b0, HASH_PRIME});
    assign o_st.clr_last      = (r_clr == BW'(MAX_BUCKETS - 1));
    assign o_st.is_ins        = (r_act == ACT_INSERT);
    assign o_st.is_del        = (r_act == ACT_DELETE);
    assign o_st.home_phase    = !r_phase;
    assign o_st.spill_differs = (r_spill != r_home);
    assign o_st.cnt_over      = (r_cnt_q > CW'(SPILL_LIMIT));
    assign o_st.cnt_full      = (r_cnt_q >= CW'(BUCKET_SLOTS));
    assign o_st.scan_end      = (r_i >= r_cnt_q);
    assign o_st.key_eq        = (r_key_q == r_key);

    assign idx_ext        = {10'b0, r_idx};
    assign o_valid        = r_valid;
    assign o_bucket_index = idx_ext[9:0];
    assign o_status       = r_stat;

endmodule

FILE: src/uht_ctrl.sv
`include "universal_hash_table_macros.svh"

module uht_ctrl
    import uht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MUL,
        S_ADD,
        S_RECIP,
        S_QMUL,
        S_SUBQ,
        S_MODP,
        S_MODS,
        S_RDC,
        S_DISP,
        S_RDK,
        S_CMP,
        S_BEND,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = CMD_NOP;
        case (r_state)
            S_CLR: begin
                cmd = CMD_CLR;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd     = CMD_LOAD;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cmd     = CMD_MUL;
                n_state = S_ADD;
            end
            S_ADD: begin
                cmd     = CMD_ADD;
                n_state = S_RECIP;
            end
            S_RECIP: begin
                cmd     = CMD_RECIP;
                n_state = S_QMUL;
            end
            S_QMUL: begin
                cmd     = CMD_QMUL;
                n_state = S_SUBQ;
            end
            S_SUBQ: begin
                cmd     = CMD_SUBQ;
                n_state = S_MODP;
            end
            S_MODP: begin
                if (i_st.red_ge_p) begin
                    cmd = CMD_CORR;
                end else begin
                    cmd     = CMD_FIXP;
                    n_state = S_MODS;
                end
            end
            S_MODS: begin
                if (i_st.div_done) begin
                    cmd     = CMD_HOME;
                    n_state = S_RDC;
                end
            end
            S_RDC: begin
                cmd     = CMD_RDCNT;
                n_state = S_DISP;
            end
            S_DISP: begin
                if (i_st.is_ins) begin
                    if (i_st.home_phase && i_st.cnt_over) begin
                        cmd     = CMD_NEXT;
                        n_state = S_RDC;
                    end else if (i_st.cnt_full) begin
                        cmd     = CMD_FULL;
                        n_state = S_DONE;
                    end else begin
                        cmd     = CMD_INS;
                        n_state = S_DONE;
                    end
                end else begin
                    cmd     = CMD_SCAN;
                    n_state = S_RDK;
                end
            end
            S_RDK: begin
                if (i_st.scan_end) begin
                    n_state = S_BEND;
                end else begin
                    cmd     = CMD_RDKEY;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_st.is_del) begin
                    cmd     = CMD_DEL;
                    n_state = S_RDK;
                end else if (i_st.key_eq) begin
                    cmd     = CMD_HIT;
                    n_state = S_DONE;
                end else begin
                    cmd     = CMD_ADV;
                    n_state = S_RDK;
                end
            end
            S_BEND: begin
                cmd = CMD_BEND;
                if (i_st.home_phase && i_st.spill_differs) begin
                    n_state = S_RDC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                cmd     = CMD_OUT;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

    `UHT_ASSERT_NEXT(a_accept_starts_hash, (r_state == S_IDLE && i_start), (r_state == S_MUL && r_busy), "accepted transaction did not start the hash")
    `UHT_ASSERT_NEXT(a_clear_holds, (r_state == S_CLR && !i_st.clr_last), (r_state == S_CLR && r_busy), "count clearing left early")
    `UHT_ASSERT_NEXT(a_result_frees, (cmd == CMD_OUT), (!r_busy && r_state == S_IDLE), "block not free after result")
    `UHT_ASSERT_NOW(a_busy_matches, (r_state != S_IDLE), r_busy, "busy low outside idle")

endmodule
